@@ sv/http_request_header_parser_defines.svh @@
// Assertion macros shared by the request parser checker.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HRHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request parser check failed");

// next-cycle implication, disabled in reset
`define HRHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("request parser check failed");

`endif

@@ sv/hrhp_pkg.sv @@
// Shared types and constants of the HTTP request header parser.
// Holds phase, event and method codes and the token character tables.
// No dependencies.
package hrhp_pkg;

    typedef logic [3:0] phase_t;
    typedef logic [2:0] event_t;
    typedef logic [2:0] method_t;
    typedef logic [7:0] byte_t;

    localparam phase_t PH_METHOD     = 4'd0;
    localparam phase_t PH_URL_BLANK  = 4'd1;
    localparam phase_t PH_URL        = 4'd2;
    localparam phase_t PH_LINE_REST  = 4'd3;
    localparam phase_t PH_HDR_NAME   = 4'd4;
    localparam phase_t PH_HDR_BLANK  = 4'd5;
    localparam phase_t PH_HDR_DIGITS = 4'd6;
    localparam phase_t PH_HDR_SKIP   = 4'd7;
    localparam phase_t PH_BODY       = 4'd8;
    localparam phase_t PH_DONE       = 4'd9;

    localparam event_t EV_NONE     = 3'd0;
    localparam event_t EV_URL_BYTE = 3'd1;
    localparam event_t EV_URL_END  = 3'd2;
    localparam event_t EV_BODY     = 3'd3;
    localparam event_t EV_BAD      = 3'd4;

    localparam method_t METHOD_NONE = 3'd0;

    localparam byte_t CH_TAB   = 8'd9;
    localparam byte_t CH_LF    = 8'd10;
    localparam byte_t CH_CR    = 8'd13;
    localparam byte_t CH_SPACE = 8'd32;
    localparam byte_t CH_COLON = 8'd58;
    localparam byte_t CH_ZERO  = 8'd48;
    localparam byte_t CH_NINE  = 8'd57;

    localparam int NUM_VERBS = 5;
    localparam logic [3:0] CL_NAME_LEN = 4'd14;
    localparam logic [3:0] POS_MAX = 4'd15;

    // verbs: 0 GET, 1 PUT, 2 POST, 3 HEAD, 4 DELETE
    function automatic logic [3:0] verb_len(input logic [2:0] idx);
        logic [3:0] len;
        case (idx)
            3'd0:    len = 4'd3;
            3'd1:    len = 4'd3;
            3'd2:    len = 4'd4;
            3'd3:    len = 4'd4;
            3'd4:    len = 4'd6;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic byte_t verb_char(input logic [2:0] idx, input logic [3:0] pos);
        byte_t c;
        c = 8'd0;
        case (idx)
            3'd0:
                case (pos)
                    4'd0: c = "G"; 4'd1: c = "E"; 4'd2: c = "T";
                    default: c = 8'd0;
                endcase
            3'd1:
                case (pos)
                    4'd0: c = "P"; 4'd1: c = "U"; 4'd2: c = "T";
                    default: c = 8'd0;
                endcase
            3'd2:
                case (pos)
                    4'd0: c = "P"; 4'd1: c = "O"; 4'd2: c = "S"; 4'd3: c = "T";
                    default: c = 8'd0;
                endcase
            3'd3:
                case (pos)
                    4'd0: c = "H"; 4'd1: c = "E"; 4'd2: c = "A"; 4'd3: c = "D";
                    default: c = 8'd0;
                endcase
            3'd4:
                case (pos)
                    4'd0: c = "D"; 4'd1: c = "E"; 4'd2: c = "L";
                    4'd3: c = "E"; 4'd4: c = "T"; 4'd5: c = "E";
                    default: c = 8'd0;
                endcase
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic byte_t cl_char(input logic [3:0] pos);
        byte_t c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

@@ sv/http_request_header_parser.sv @@
// HTTP request header parser: method match, URL streaming, Content-Length
// extraction and body pass-through, one byte per word. Depends on hrhp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries data_byte and new_request;
//   new_request high clears the parser before this byte is taken as the
//   first byte of a request. Each input word yields exactly one output word
//   (out_valid/out_ready) with event_res, out_byte, method, content_length,
//   complete and last_body.
//   cfg_we/cfg_wdata write max_body_length, the saturation bound of the
//   parsed length; write it only while no words are in flight.
//   A word accepted into the input register is parsed as it moves into the
//   output register, from which it is offered on the output.
//   Throughput: one word per cycle unless the output stalls; the per-byte
//   state update is a single pass of combinational logic, its longest path
//   the length update (times ten, add digit, compare against the bound).
//   Reset: parser state returns to the method phase, max_body_length to
//   65535, both registers empty.
//   Stall: when out_ready is low the output word holds, the input register
//   fills, and in_ready drops until the output is taken.
module http_request_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        new_request,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  out_byte,
    output logic [2:0]  method,
    output logic [31:0] content_length,
    output logic        complete,
    output logic        last_body,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic                 s1_valid_reg, s1_valid_next;
    hrhp_pkg::byte_t      s1_byte_reg;
    logic                 s1_new_reg;
    logic                 s1_go;
    logic                 in_accept;

    logic                 out_valid_reg, out_valid_next;
    hrhp_pkg::event_t     event_reg, event_next;
    hrhp_pkg::byte_t      byte_reg, byte_next;
    hrhp_pkg::method_t    method_reg;
    logic [31:0]          length_reg;
    logic                 complete_reg, complete_next;
    logic                 last_reg, last_next;

    logic [31:0]          max_len_reg;

    hrhp_pkg::phase_t     phase_reg, phase_next, cur_phase;
    logic [4:0]           cand_reg, cand_next, cur_cand;
    logic [3:0]           tpos_reg, tpos_next, cur_tpos;
    hrhp_pkg::method_t    mcode_reg, mcode_next, cur_mcode;
    logic                 name_ok_reg, name_ok_next, cur_name_ok;
    logic                 empty_reg, empty_next, cur_empty;
    logic                 crp_reg, crp_next, cur_crp;
    logic [31:0]          lval_reg, lval_next, cur_lval;
    logic [31:0]          remain_reg, remain_next, cur_remain;

    hrhp_pkg::byte_t      b;
    logic                 is_blank, is_digit, is_crlf, bad;
    logic [35:0]          times_ten, digit_sum;
    logic [31:0]          lval_digit;
    logic [31:0]          remain_dec;
    hrhp_pkg::method_t    found;

    assign in_accept = in_valid && in_ready;
    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign b        = s1_byte_reg;
    assign is_blank = (b == hrhp_pkg::CH_SPACE) || (b == hrhp_pkg::CH_TAB);
    assign is_digit = (b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE);
    assign is_crlf  = (b == hrhp_pkg::CH_CR) || (b == hrhp_pkg::CH_LF);

    // clear on new_request before parsing this byte
    assign cur_phase   = s1_new_reg ? hrhp_pkg::PH_METHOD : phase_reg;
    assign cur_cand    = s1_new_reg ? 5'h1F : cand_reg;
    assign cur_tpos    = s1_new_reg ? 4'd0 : tpos_reg;
    assign cur_mcode   = s1_new_reg ? hrhp_pkg::METHOD_NONE : mcode_reg;
    assign cur_name_ok = s1_new_reg ? 1'b1 : name_ok_reg;
    assign cur_empty   = s1_new_reg ? 1'b1 : empty_reg;
    assign cur_crp     = s1_new_reg ? 1'b0 : crp_reg;
    assign cur_lval    = s1_new_reg ? 32'd0 : lval_reg;
    assign cur_remain  = s1_new_reg ? 32'd0 : remain_reg;

    // saturating decimal accumulate
    assign times_ten  = ({4'd0, cur_lval} << 3) + ({4'd0, cur_lval} << 1);
    assign digit_sum  = times_ten + {32'd0, b[3:0] - hrhp_pkg::CH_ZERO[3:0]};
    assign lval_digit = (digit_sum > {4'd0, max_len_reg}) ? max_len_reg : digit_sum[31:0];

    assign remain_dec = (cur_remain != 32'd0) ? cur_remain - 32'd1 : cur_remain;

    always_comb
    begin
        found = hrhp_pkg::METHOD_NONE;
        for (int i = 0; i < hrhp_pkg::NUM_VERBS; i++)
        begin
            if (cur_cand[i] && (hrhp_pkg::verb_len(3'(i)) == cur_tpos))
                found = 3'(i + 1);
        end
    end

    always_comb
    begin
        phase_next   = cur_phase;
        cand_next    = cur_cand;
        tpos_next    = cur_tpos;
        mcode_next   = cur_mcode;
        name_ok_next = cur_name_ok;
        empty_next   = cur_empty;
        crp_next     = cur_crp;
        lval_next    = cur_lval;
        remain_next  = cur_remain;
        event_next   = hrhp_pkg::EV_NONE;
        byte_next    = 8'd0;
        complete_next = 1'b0;
        last_next    = 1'b0;
        bad          = 1'b0;

        case (cur_phase)
            hrhp_pkg::PH_METHOD:
            begin
                if (b == hrhp_pkg::CH_SPACE)
                begin
                    if (found != hrhp_pkg::METHOD_NONE)
                    begin
                        mcode_next = found;
                        phase_next = hrhp_pkg::PH_URL_BLANK;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                else if (is_crlf)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < hrhp_pkg::NUM_VERBS; i++)
                    begin
                        if ((cur_tpos >= hrhp_pkg::verb_len(3'(i))) ||
                            (hrhp_pkg::verb_char(3'(i), cur_tpos) != b))
                            cand_next[i] = 1'b0;
                    end
                    if (cur_tpos < hrhp_pkg::POS_MAX)
                        tpos_next = cur_tpos + 4'd1;
                end
            end
            hrhp_pkg::PH_URL_BLANK:
            begin
                if (is_blank)
                begin
                    phase_next = cur_phase;
                end
                else if (is_crlf)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    event_next = hrhp_pkg::EV_URL_BYTE;
                    byte_next  = b;
                    phase_next = hrhp_pkg::PH_URL;
                end
            end
            hrhp_pkg::PH_URL:
            begin
                if (b == hrhp_pkg::CH_SPACE)
                begin
                    event_next = hrhp_pkg::EV_URL_END;
                    crp_next   = 1'b0;
                    phase_next = hrhp_pkg::PH_LINE_REST;
                end
                else if (is_crlf)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    event_next = hrhp_pkg::EV_URL_BYTE;
                    byte_next  = b;
                end
            end
            hrhp_pkg::PH_LINE_REST:
            begin
                if ((b == hrhp_pkg::CH_LF) && cur_crp)
                begin
                    crp_next     = 1'b0;
                    empty_next   = 1'b1;
                    name_ok_next = 1'b1;
                    tpos_next    = 4'd0;
                    phase_next   = hrhp_pkg::PH_HDR_NAME;
                end
                else
                begin
                    crp_next = (b == hrhp_pkg::CH_CR);
                end
            end
            hrhp_pkg::PH_HDR_NAME, hrhp_pkg::PH_HDR_BLANK,
            hrhp_pkg::PH_HDR_DIGITS, hrhp_pkg::PH_HDR_SKIP:
            begin
                if ((b == hrhp_pkg::CH_LF) && cur_crp)
                begin
                    crp_next = 1'b0;
                    if (cur_empty)
                    begin
                        remain_next = cur_lval;
                        if (cur_lval == 32'd0)
                        begin
                            complete_next = 1'b1;
                            phase_next    = hrhp_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = hrhp_pkg::PH_BODY;
                        end
                    end
                    else
                    begin
                        empty_next   = 1'b1;
                        name_ok_next = 1'b1;
                        tpos_next    = 4'd0;
                        phase_next   = hrhp_pkg::PH_HDR_NAME;
                    end
                end
                else
                begin
                    if (b == hrhp_pkg::CH_CR)
                    begin
                        if (cur_crp)
                            empty_next = 1'b0;
                        crp_next = 1'b1;
                    end
                    else
                    begin
                        crp_next   = 1'b0;
                        empty_next = 1'b0;
                    end

                    if (cur_phase == hrhp_pkg::PH_HDR_NAME)
                    begin
                        if (b == hrhp_pkg::CH_COLON)
                        begin
                            if (cur_name_ok && (cur_tpos == hrhp_pkg::CL_NAME_LEN))
                            begin
                                lval_next  = 32'd0;
                                phase_next = hrhp_pkg::PH_HDR_BLANK;
                            end
                            else
                            begin
                                phase_next = hrhp_pkg::PH_HDR_SKIP;
                            end
                        end
                        else
                        begin
                            if ((cur_tpos >= hrhp_pkg::CL_NAME_LEN) ||
                                (hrhp_pkg::cl_char(cur_tpos) != b))
                                name_ok_next = 1'b0;
                            if (cur_tpos < hrhp_pkg::POS_MAX)
                                tpos_next = cur_tpos + 4'd1;
                        end
                    end
                    else if (cur_phase == hrhp_pkg::PH_HDR_BLANK)
                    begin
                        if (is_blank)
                        begin
                            phase_next = cur_phase;
                        end
                        else if (is_digit)
                        begin
                            lval_next  = lval_digit;
                            phase_next = hrhp_pkg::PH_HDR_DIGITS;
                        end
                        else
                        begin
                            phase_next = hrhp_pkg::PH_HDR_SKIP;
                        end
                    end
                    else if (cur_phase == hrhp_pkg::PH_HDR_DIGITS)
                    begin
                        if (is_digit)
                            lval_next = lval_digit;
                        else
                            phase_next = hrhp_pkg::PH_HDR_SKIP;
                    end
                end
            end
            hrhp_pkg::PH_BODY:
            begin
                event_next  = hrhp_pkg::EV_BODY;
                byte_next   = b;
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    last_next     = 1'b1;
                    complete_next = 1'b1;
                    phase_next    = hrhp_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = hrhp_pkg::PH_DONE;
            end
        endcase

        if (bad)
        begin
            mcode_next    = hrhp_pkg::METHOD_NONE;
            phase_next    = hrhp_pkg::PH_DONE;
            event_next    = hrhp_pkg::EV_BAD;
            byte_next     = 8'd0;
            complete_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= 32'd65535;
            phase_reg     <= hrhp_pkg::PH_METHOD;
            cand_reg      <= 5'h1F;
            tpos_reg      <= 4'd0;
            mcode_reg     <= hrhp_pkg::METHOD_NONE;
            name_ok_reg   <= 1'b1;
            empty_reg     <= 1'b1;
            crp_reg       <= 1'b0;
            lval_reg      <= 32'd0;
            remain_reg    <= 32'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            if (s1_go)
            begin
                phase_reg   <= phase_next;
                cand_reg    <= cand_next;
                tpos_reg    <= tpos_next;
                mcode_reg   <= mcode_next;
                name_ok_reg <= name_ok_next;
                empty_reg   <= empty_next;
                crp_reg     <= crp_next;
                lval_reg    <= lval_next;
                remain_reg  <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_new_reg  <= new_request;
        end
        if (s1_go)
        begin
            event_reg    <= event_next;
            byte_reg     <= byte_next;
            method_reg   <= mcode_next;
            length_reg   <= lval_next;
            complete_reg <= complete_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign out_byte       = byte_reg;
    assign method         = method_reg;
    assign content_length = length_reg;
    assign complete       = complete_reg;
    assign last_body      = last_reg;

endmodule

@@ sv/hrhp_checker.sv @@
// Port-level checks for the HTTP request header parser.
// Depends on hrhp_pkg and http_request_header_parser_defines.svh; bound to http_request_header_parser.
`include "http_request_header_parser_defines.svh"

module hrhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [7:0]  out_byte,
    input logic [2:0]  method,
    input logic        complete,
    input logic        last_body
);

    logic        stalled;
    logic [15:0] out_word;
    logic        is_bad, bad_ok, is_last, is_data, quiet_done;

    assign stalled    = out_valid && !out_ready;
    assign out_word   = {event_res, out_byte, method, complete, last_body};
    assign is_bad     = out_valid && (event_res == hrhp_pkg::EV_BAD);
    assign bad_ok     = complete && (method == hrhp_pkg::METHOD_NONE) && (out_byte == 8'd0);
    assign is_last    = out_valid && last_body;
    assign is_data    = (event_res == hrhp_pkg::EV_URL_BYTE) || (event_res == hrhp_pkg::EV_BODY);
    assign quiet_done = out_valid && complete && !last_body && (event_res != hrhp_pkg::EV_BAD);

    `HRHP_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word))
    `HRHP_ASSERT_NOW(a_bad_word, is_bad, bad_ok)
    `HRHP_ASSERT_NOW(a_last_is_body, is_last, complete && (event_res == hrhp_pkg::EV_BODY))
    `HRHP_ASSERT_NOW(a_byte_only_data, out_valid && !is_data, out_byte == 8'd0)
    `HRHP_ASSERT_NOW(a_quiet_finish, quiet_done, event_res == hrhp_pkg::EV_NONE)

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .out_byte  (out_byte),
    .method    (method),
    .complete  (complete),
    .last_body (last_body)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for http_request_header_parser: directed and random request
// streams, with random stalls on both channels, checked word by word against a model.
// Depends on hrhp_pkg and the parser RTL.
module testbench;

    localparam hrhp_pkg::method_t METHOD_GET    = 3'd1;
    localparam hrhp_pkg::method_t METHOD_PUT    = 3'd2;
    localparam hrhp_pkg::method_t METHOD_POST   = 3'd3;
    localparam hrhp_pkg::method_t METHOD_HEAD   = 3'd4;
    localparam hrhp_pkg::method_t METHOD_DELETE = 3'd5;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WORDS_PER_PHASE = 100;

    typedef struct packed {
        hrhp_pkg::event_t  kind;
        hrhp_pkg::byte_t   data;
        hrhp_pkg::method_t meth;
        logic [31:0]       length;
        logic              done;
        logic              last;
    } parse_result_t;

    class request_shadow_t;
        string             verb_text [5];
        hrhp_pkg::method_t verb_code [5];
        string             length_name;
        logic [31:0]       length_cap;
        hrhp_pkg::phase_t  phase;
        logic [4:0]        candidates;
        logic [3:0]        token_pos;
        hrhp_pkg::method_t method_code;
        logic              name_ok;
        logic              line_empty;
        logic              cr_seen;
        logic [31:0]       length_value;
        logic [31:0]       body_left;
        parse_result_t     results_due [$];
        int                mismatches;
        int                results_seen;

        function new();
            verb_text    = '{"GET", "PUT", "POST", "HEAD", "DELETE"};
            verb_code    = '{METHOD_GET, METHOD_PUT, METHOD_POST, METHOD_HEAD, METHOD_DELETE};
            length_name  = "Content-Length";
            length_cap   = 32'd65535;
            mismatches   = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            phase        = hrhp_pkg::PH_METHOD;
            candidates   = 5'h1F;
            token_pos    = 4'd0;
            method_code  = hrhp_pkg::METHOD_NONE;
            name_ok      = 1'b1;
            line_empty   = 1'b1;
            cr_seen      = 1'b0;
            length_value = 32'd0;
            body_left    = 32'd0;
        endfunction

        function void push_digit(hrhp_pkg::byte_t b);
            logic [63:0] v;
            v = 64'(length_value) * 64'd10 + 64'(b - hrhp_pkg::CH_ZERO);
            if (v > 64'(length_cap))
                v = 64'(length_cap);
            length_value = v[31:0];
        endfunction

        function void take_byte(hrhp_pkg::byte_t b, logic fresh);
            parse_result_t     r;
            bit                bad;
            hrhp_pkg::method_t found;
            r      = '0;
            r.kind = hrhp_pkg::EV_NONE;
            bad    = 1'b0;
            if (fresh)
                restart();
            case (phase)
                hrhp_pkg::PH_METHOD:
                begin
                    if (b == hrhp_pkg::CH_SPACE)
                    begin
                        found = hrhp_pkg::METHOD_NONE;
                        for (int i = 0; i < 5; i++)
                            if (candidates[i] && verb_text[i].len() == token_pos)
                                found = verb_code[i];
                        if (found != hrhp_pkg::METHOD_NONE)
                        begin
                            method_code = found;
                            phase       = hrhp_pkg::PH_URL_BLANK;
                        end
                        else
                            bad = 1'b1;
                    end
                    else if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF)
                        bad = 1'b1;
                    else
                    begin
                        for (int i = 0; i < 5; i++)
                            if (token_pos >= verb_text[i].len() ||
                                verb_text[i].getc(token_pos) != b)
                                candidates[i] = 1'b0;
                        if (token_pos < hrhp_pkg::POS_MAX)
                            token_pos++;
                    end
                end
                hrhp_pkg::PH_URL_BLANK:
                begin
                    if (b == hrhp_pkg::CH_SPACE || b == hrhp_pkg::CH_TAB)
                        ;
                    else if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF)
                        bad = 1'b1;
                    else
                    begin
                        r.kind = hrhp_pkg::EV_URL_BYTE;
                        r.data = b;
                        phase  = hrhp_pkg::PH_URL;
                    end
                end
                hrhp_pkg::PH_URL:
                begin
                    if (b == hrhp_pkg::CH_SPACE)
                    begin
                        r.kind  = hrhp_pkg::EV_URL_END;
                        cr_seen = 1'b0;
                        phase   = hrhp_pkg::PH_LINE_REST;
                    end
                    else if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF)
                        bad = 1'b1;
                    else
                    begin
                        r.kind = hrhp_pkg::EV_URL_BYTE;
                        r.data = b;
                    end
                end
                hrhp_pkg::PH_LINE_REST:
                begin
                    if (b == hrhp_pkg::CH_LF && cr_seen)
                    begin
                        cr_seen    = 1'b0;
                        line_empty = 1'b1;
                        name_ok    = 1'b1;
                        token_pos  = 4'd0;
                        phase      = hrhp_pkg::PH_HDR_NAME;
                    end
                    else
                        cr_seen = (b == hrhp_pkg::CH_CR);
                end
                hrhp_pkg::PH_HDR_NAME, hrhp_pkg::PH_HDR_BLANK,
                hrhp_pkg::PH_HDR_DIGITS, hrhp_pkg::PH_HDR_SKIP:
                begin
                    if (b == hrhp_pkg::CH_LF && cr_seen)
                    begin
                        cr_seen = 1'b0;
                        if (line_empty)
                        begin
                            body_left = length_value;
                            if (body_left == 32'd0)
                            begin
                                r.done = 1'b1;
                                phase  = hrhp_pkg::PH_DONE;
                            end
                            else
                                phase = hrhp_pkg::PH_BODY;
                        end
                        else
                        begin
                            line_empty = 1'b1;
                            name_ok    = 1'b1;
                            token_pos  = 4'd0;
                            phase      = hrhp_pkg::PH_HDR_NAME;
                        end
                    end
                    else
                    begin
                        if (b == hrhp_pkg::CH_CR)
                        begin
                            if (cr_seen)
                                line_empty = 1'b0;
                            cr_seen = 1'b1;
                        end
                        else
                        begin
                            cr_seen    = 1'b0;
                            line_empty = 1'b0;
                        end
                        if (phase == hrhp_pkg::PH_HDR_NAME)
                        begin
                            if (b == hrhp_pkg::CH_COLON)
                            begin
                                if (name_ok && token_pos == hrhp_pkg::CL_NAME_LEN)
                                begin
                                    length_value = 32'd0;
                                    phase        = hrhp_pkg::PH_HDR_BLANK;
                                end
                                else
                                    phase = hrhp_pkg::PH_HDR_SKIP;
                            end
                            else
                            begin
                                if (token_pos >= hrhp_pkg::CL_NAME_LEN ||
                                    length_name.getc(token_pos) != b)
                                    name_ok = 1'b0;
                                if (token_pos < hrhp_pkg::POS_MAX)
                                    token_pos++;
                            end
                        end
                        else if (phase == hrhp_pkg::PH_HDR_BLANK)
                        begin
                            if (b == hrhp_pkg::CH_SPACE || b == hrhp_pkg::CH_TAB)
                                ;
                            else if (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE)
                            begin
                                push_digit(b);
                                phase = hrhp_pkg::PH_HDR_DIGITS;
                            end
                            else
                                phase = hrhp_pkg::PH_HDR_SKIP;
                        end
                        else if (phase == hrhp_pkg::PH_HDR_DIGITS)
                        begin
                            if (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE)
                                push_digit(b);
                            else
                                phase = hrhp_pkg::PH_HDR_SKIP;
                        end
                    end
                end
                hrhp_pkg::PH_BODY:
                begin
                    r.kind = hrhp_pkg::EV_BODY;
                    r.data = b;
                    if (body_left > 32'd0)
                        body_left--;
                    if (body_left == 32'd0)
                    begin
                        r.last = 1'b1;
                        r.done = 1'b1;
                        phase  = hrhp_pkg::PH_DONE;
                    end
                end
                default:
                    phase = hrhp_pkg::PH_DONE;
            endcase
            if (bad)
            begin
                method_code = hrhp_pkg::METHOD_NONE;
                phase       = hrhp_pkg::PH_DONE;
                r.kind      = hrhp_pkg::EV_BAD;
                r.data      = 8'd0;
                r.done      = 1'b1;
            end
            r.meth   = method_code;
            r.length = length_value;
            results_due.push_back(r);
        endfunction

        function void match_result(parse_result_t got);
            parse_result_t want;
            results_seen++;
            if (results_due.size() == 0)
            begin
                $error("result word with nothing pending");
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (got !== want)
                mismatches++;
            if (got.kind !== want.kind)
                $error("event_res: expected %0d, got %0d", want.kind, got.kind);
            if (got.data !== want.data)
                $error("out_byte: expected %0h, got %0h", want.data, got.data);
            if (got.meth !== want.meth)
                $error("method: expected %0d, got %0d", want.meth, got.meth);
            if (got.length !== want.length)
                $error("content_length: expected %0d, got %0d", want.length, got.length);
            if (got.done !== want.done)
                $error("complete: expected %0b, got %0b", want.done, got.done);
            if (got.last !== want.last)
                $error("last_body: expected %0b, got %0b", want.last, got.last);
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    hrhp_pkg::byte_t   data_byte   = 8'd0;
    logic              new_request = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    hrhp_pkg::event_t  event_res;
    hrhp_pkg::byte_t   out_byte;
    hrhp_pkg::method_t method;
    logic [31:0]       content_length;
    logic              complete;
    logic              last_body;
    logic              cfg_we      = 1'b0;
    logic [31:0]       cfg_wdata   = 32'd0;

    int                send_gap_pct   = 8;
    int                recv_stall_pct = 63;
    int                words_sent     = 0;
    int                requests_sent  = 0;
    int                word_goal      = 0;
    longint            cycle_count    = 0;
    hrhp_pkg::byte_t   request_words [$];

    request_shadow_t shadow = new();

    http_request_header_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .new_request    (new_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .out_byte       (out_byte),
        .method         (method),
        .content_length (content_length),
        .complete       (complete),
        .last_body      (last_body),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.match_result(parse_result_t'({event_res, out_byte, method,
                                                 content_length, complete, last_body}));
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit");
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            request_words.push_back(s[k]);
    endfunction

    task automatic send_word(input hrhp_pkg::byte_t b, input logic fresh);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        new_request <= fresh;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.take_byte(b, fresh);
        words_sent++;
    endtask

    task automatic send_request_words();
        foreach (request_words[k])
            send_word(request_words[k], k == 0);
        requests_sent++;
    endtask

    task automatic send_text(input string s);
        request_words.delete();
        add_text(s);
        send_request_words();
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (shadow.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_length_cap(input logic [31:0] cap);
        pause_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.length_cap = cap;
    endtask

    task automatic send_random_request();
        string near_miss [4];
        string verb;
        int    pick;
        near_miss = '{"Content-Lengthx: 5", "content-length: 5", "Content-Lengt: 5",
                      "Content-Length 5"};
        request_words.delete();
        verb = shadow.verb_text[$urandom_range(4)];
        pick = $urandom_range(15);
        if (pick != 0)
            add_text(verb);
        if (pick == 1)
            request_words.push_back(hrhp_pkg::byte_t'($urandom_range(65, 90)));
        else if (pick == 2)
            void'(request_words.pop_back());
        else if (pick == 3)
            request_words[$urandom_range(request_words.size() - 1)] =
                hrhp_pkg::byte_t'($urandom_range(255));
        else if (pick == 4)
            request_words.push_back($urandom_range(1) ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF);
        request_words.push_back(hrhp_pkg::CH_SPACE);
        repeat ($urandom_range(2))
            request_words.push_back($urandom_range(1) ? hrhp_pkg::CH_SPACE : hrhp_pkg::CH_TAB);
        if ($urandom_range(19) == 0)
            request_words.push_back($urandom_range(1) ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF);
        repeat ($urandom_range(1, 6))
            request_words.push_back($urandom_range(3) == 0
                                    ? hrhp_pkg::byte_t'($urandom_range(255))
                                    : hrhp_pkg::byte_t'($urandom_range(33, 126)));
        add_text(" HTTP/1.1");
        if ($urandom_range(7) == 0)
            add_text("\015x\ny");
        add_text("\015\n");
        repeat ($urandom_range(3))
        begin
            case ($urandom_range(7))
                0, 1, 2:
                begin
                    add_text("Content-Length:");
                    repeat ($urandom_range(2))
                        request_words.push_back($urandom_range(1) ? hrhp_pkg::CH_SPACE
                                                                  : hrhp_pkg::CH_TAB);
                    pick = $urandom_range(9);
                    if (pick == 0)
                        add_text("x7");
                    else if (pick == 1)
                        repeat ($urandom_range(10, 14))
                            request_words.push_back(hrhp_pkg::byte_t'(
                                $urandom_range(hrhp_pkg::CH_ZERO, hrhp_pkg::CH_NINE)));
                    else
                    begin
                        if (pick == 2)
                            add_text("00");
                        add_text($sformatf("%0d", $urandom_range(30)));
                    end
                    if ($urandom_range(3) == 0)
                        add_text(" 9;");
                end
                3:
                    add_text("Host: h");
                4:
                    add_text(near_miss[$urandom_range(3)]);
                5:
                    add_text("Accept");
                6:
                    repeat ($urandom_range(1, 5))
                        request_words.push_back(hrhp_pkg::byte_t'($urandom_range(255)));
                default:
                    add_text("A\015B\nC");
            endcase
            add_text("\015\n");
        end
        if ($urandom_range(9) != 0)
            add_text("\015\n");
        repeat ($urandom_range(20))
            request_words.push_back(hrhp_pkg::byte_t'($urandom_range(255)));
        if ($urandom_range(7) == 0)
        begin
            pick = $urandom_range(1, request_words.size());
            while (request_words.size() > pick)
                void'(request_words.pop_back());
        end
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
                send_word(hrhp_pkg::byte_t'($urandom_range(255)), $urandom_range(7) == 0);
        send_request_words();
    endtask

    initial
    begin
        logic [31:0] caps [6];
        int          gaps [3];
        int          stalls [3];
        caps   = '{32'd0, 32'd12, 32'hFFFF_FFFF, 32'd300, 32'd5, 32'd65535};
        gaps   = '{8, 63, 0};
        stalls = '{63, 8, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        request_words.delete();
        add_text("GET /");
        request_words.push_back(8'hFF);
        request_words.push_back(8'h00);
        add_text(" \015\n\015\nZ");
        send_request_words();
        send_text("PUT \t/p q\015\nContent-Length:\t 3x\015\nHost: a\015\n\015\nabcd");
        send_text("HEAD /h\n");
        send_text("DELETE  /d \015\015\nX\nY\015Z\015\n\015\n");
        send_text("GEX /");
        send_text(" ");
        send_text("GE\015");
        send_text("POST \t\015");
        send_text("POST /y \015\nContent-Length: 2\015\nContent-Length: 1\015\n\015\nkl");

        for (int s = 0; s < 6; s++)
        begin
            set_length_cap(caps[s]);
            send_gap_pct   = gaps[s / 2];
            recv_stall_pct = stalls[s / 2];
            word_goal      = words_sent + WORDS_PER_PHASE;
            while (words_sent < word_goal)
                send_random_request();
        end
        pause_until_drained();

        $display("%0d requests, %0d bytes sent, %0d result words checked",
                 requests_sent, words_sent, shadow.results_seen);
        $display("length bound at 65535, 0, 12, all ones, 300 and 5; stalls on each side");
        if (shadow.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/hrhp_pkg.sv
sv/http_request_header_parser.sv
sv/hrhp_checker.sv
tb/testbench.sv
